// ----- design/gocc_pkg.sv -----
// Shared types and constants for the grid obstacle collision checker.
// Used by the controller, the datapath and the top level; depends on nothing.
package gocc_pkg;

    localparam int COORD_W    = 16;
    localparam int RADIUS_W   = 12;
    localparam int RSUM_W     = RADIUS_W + 1;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;
    localparam int ENTRY_W    = 2 * COORD_W + RADIUS_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int RSQ_W      = 2 * RSUM_W;
    localparam int DIST_W     = SQ_W + 1 + 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Y_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Z_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_X_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Y_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Z_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_RADIUS = 3'd6;

    localparam logic [COORD_W-1:0]  RST_BOUND_X_HIGH = 16'd25;
    localparam logic [COORD_W-1:0]  RST_BOUND_Y_HIGH = 16'd25;
    localparam logic [COORD_W-1:0]  RST_BOUND_Z_HIGH = 16'd10;

    typedef struct packed {
        logic capture;
        logic insert;
        logic scan_clear;
        logic scan_issue;
        logic load_result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_query;
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
    } t_ctrl_status;

endpackage

// ----- design/gocc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used by the datapath for the obstacle table.
module gocc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/gocc_ctrl.sv -----
// Controller state machine of the collision checker: sequences insert and scan.
// Depends on gocc_pkg for the command and status structs.
module gocc_ctrl import gocc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_query) begin
                    o_cmd.scan_clear = 1'b1;
                    n_state = i_status.count_zero ? S_DONE : S_SCAN;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.load_result) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

// ----- design/gocc_dp.sv -----
// Datapath of the collision checker: configuration registers, item register,
// obstacle table, pipelined distance test and result register. Uses gocc_pkg, gocc_ram.
module gocc_dp import gocc_pkg::*; #(
    parameter int MAX_OBSTACLES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_status          o_status
);

    localparam int IdxW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CntW = $clog2(MAX_OBSTACLES + 1);

    logic [COORD_W-1:0]  r_bx_lo, r_by_lo, r_bz_lo, r_bx_hi, r_by_hi, r_bz_hi;
    logic [RADIUS_W-1:0] r_robot;

    logic                r_cmd;
    logic [COORD_W-1:0]  r_px, r_py, r_pz;
    logic [RADIUS_W-1:0] r_nr;

    logic [CntW-1:0]     r_count;
    logic [IdxW-1:0]     r_idx;
    logic                r_full;
    logic                r_hit;
    logic                is_full;
    logic                wr_en;

    logic [ENTRY_W-1:0]  rd_data;
    logic [COORD_W-1:0]  ent_x, ent_y;
    logic [RADIUS_W-1:0] ent_r;
    logic signed [COORD_W:0] dx, dy;

    logic                r_v1, r_v2, r_v3;
    logic [COORD_W-1:0]  r_adx, r_ady;
    logic [RSUM_W-1:0]   r_rsum;
    logic [SQ_W-1:0]     r_dx2, r_dy2;
    logic [RSQ_W-1:0]    r_r2;
    logic [SQ_W:0]       dist_sum;
    logic [DIST_W-1:0]   dist_lhs;
    logic                in_reach;
    logic                oob;

    logic                r_res_oob, r_res_hit, r_res_full;
    logic [COUNT_W-1:0]  r_res_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx_lo <= '0;
            r_by_lo <= '0;
            r_bz_lo <= '0;
            r_bx_hi <= RST_BOUND_X_HIGH;
            r_by_hi <= RST_BOUND_Y_HIGH;
            r_bz_hi <= RST_BOUND_Z_HIGH;
            r_robot <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOUND_X_LOW:  r_bx_lo <= i_cfg_data;
                CFG_BOUND_Y_LOW:  r_by_lo <= i_cfg_data;
                CFG_BOUND_Z_LOW:  r_bz_lo <= i_cfg_data;
                CFG_BOUND_X_HIGH: r_bx_hi <= i_cfg_data;
                CFG_BOUND_Y_HIGH: r_by_hi <= i_cfg_data;
                CFG_BOUND_Z_HIGH: r_bz_hi <= i_cfg_data;
                CFG_ROBOT_RADIUS: r_robot <= i_cfg_data[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_s_tuser;
            r_px  <= i_s_tdata[COORD_W-1:0];
            r_py  <= i_s_tdata[2*COORD_W-1:COORD_W];
            r_pz  <= i_s_tdata[3*COORD_W-1:2*COORD_W];
            r_nr  <= i_s_tdata[3*COORD_W+RADIUS_W-1:3*COORD_W];
        end
    end

    assign is_full = (r_count == CntW'(MAX_OBSTACLES));
    assign wr_en   = i_cmd.insert && !is_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (wr_en) begin
            r_count <= r_count + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_full <= is_full;
        end else if (i_cmd.scan_clear) begin
            r_full <= 1'b0;
        end
        if (i_cmd.scan_clear) begin
            r_idx <= '0;
        end else if (i_cmd.scan_issue) begin
            r_idx <= r_idx + IdxW'(1);
        end
    end

    gocc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OBSTACLES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IdxW-1:0]),
        .i_wr_data ({r_nr, r_py, r_px}),
        .i_rd_en   (i_cmd.scan_issue),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign ent_x = rd_data[COORD_W-1:0];
    assign ent_y = rd_data[2*COORD_W-1:COORD_W];
    assign ent_r = rd_data[ENTRY_W-1:2*COORD_W];
    assign dx = $signed({r_px[COORD_W-1], r_px}) - $signed({ent_x[COORD_W-1], ent_x});
    assign dy = $signed({r_py[COORD_W-1], r_py}) - $signed({ent_y[COORD_W-1], ent_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adx  <= dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
        r_ady  <= dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
        r_rsum <= RSUM_W'(ent_r) + RSUM_W'(r_robot);
        r_dx2  <= r_adx * r_adx;
        r_dy2  <= r_ady * r_ady;
        r_r2   <= r_rsum * r_rsum;
    end

    // Both offsets are scaled by sixteen, so the planar sum carries a factor of 256.
    assign dist_sum = (SQ_W + 1)'(r_dx2) + (SQ_W + 1)'(r_dy2);
    assign dist_lhs = {dist_sum, 8'b0};
    assign in_reach = (dist_lhs <= DIST_W'(r_r2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clear) begin
            r_hit <= 1'b0;
        end else if (r_v3 && in_reach) begin
            r_hit <= 1'b1;
        end
    end

    assign oob = ($signed(r_px) < $signed(r_bx_lo)) || ($signed(r_px) > $signed(r_bx_hi)) ||
                 ($signed(r_py) < $signed(r_by_lo)) || ($signed(r_py) > $signed(r_by_hi)) ||
                 ($signed(r_pz) < $signed(r_bz_lo)) || ($signed(r_pz) > $signed(r_bz_hi));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_res_oob   <= (r_cmd == CMD_QUERY) && oob;
            r_res_hit   <= (r_cmd == CMD_QUERY) && r_hit;
            r_res_count <= COUNT_W'(r_count);
            r_res_full  <= (r_cmd == CMD_INSERT) && r_full;
        end
    end

    assign o_m_tdata = {{(M_TDATA_W - COUNT_W - 3){1'b0}}, r_res_full, r_res_count,
                        r_res_hit, r_res_oob};

    assign o_status.is_query   = (r_cmd == CMD_QUERY);
    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_last  = ((CntW'(r_idx) + CntW'(1)) == r_count);
    assign o_status.pipe_busy  = r_v1 || r_v2 || r_v3;

endmodule

// ----- design/grid_obstacle_collision_checker.sv -----
// Top level of the grid obstacle collision checker.
// Joins gocc_ctrl and gocc_dp; depends on gocc_pkg.
//
// Usage: each input beat on the slave stream is either an insert (tuser 0),
// which stores an obstacle centre and radius in a table of MAX_OBSTACLES
// entries, or a query (tuser 1), which tests a grid position against the
// configured box and against every stored obstacle enlarged by the robot
// radius. Every input beat yields exactly one output beat.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while the block is idle.
// Flow: an insert goes from idle through execute to done, which loads its
// result into the output register. A query scans the table through one
// RAM read port, one entry per cycle, into a distance pipeline (registered
// read, offsets and radius sum, squares, hit flag) and then drains it; an
// empty table skips the scan. One item is worked on at a time; the next
// beat is accepted as soon as the previous result sits in the output
// register, even while the receiver stalls. A stalled output holds its
// beat and the block waits before loading a newer result. Reset clears
// the obstacle count, the control state, the pipeline valid flags and the
// configuration registers to their defaults; the table needs no clearing.
module grid_obstacle_collision_checker import gocc_pkg::*; #(
    parameter int MAX_OBSTACLES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pos_x [15:0], pos_y [31:16], pos_z [47:32], new_radius [59:48], zeros above.
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // command [0].
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_of_bounds [0], hits_obstacle [1], stored_count [8:2], table_full [9], zeros above.
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    assign o_cfg_ready = 1'b1;

    gocc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gocc_dp #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_m_tdata   (o_m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for grid_obstacle_collision_checker: obstacle inserts and
// position queries are streamed in, each result beat is checked against a built-in predictor.
// Depends on gocc_pkg and the RTL of the block; needs no other file.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gocc_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_GAP    = 8;
    localparam int TAIL_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int REPORT_LIMIT = 10;
    localparam int NEAR_SPAN    = 60;
    localparam int OFFSET_SPAN  = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct {
        logic                       cmd;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [RADIUS_W-1:0]        radius;
    } t_map_op;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic               oob;
        logic               hit;
        logic [COUNT_W-1:0] count;
        logic               full;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = CMD_INSERT;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    t_map_op    map_ops[$];
    t_map_op    map_op_on_bus;
    t_cfg_write cfg_writes[$];
    t_cfg_write cfg_on_bus;
    t_verdict   verdicts[$];

    logic signed [COORD_W-1:0] placed_x[$];
    logic signed [COORD_W-1:0] placed_y[$];

    logic signed [COORD_W-1:0] obst_x[TABLE_DEPTH];
    logic signed [COORD_W-1:0] obst_y[TABLE_DEPTH];
    logic [RADIUS_W-1:0]       obst_size[TABLE_DEPTH];
    int                        obst_count = 0;

    logic signed [COORD_W-1:0] lim_x_lo = '0;
    logic signed [COORD_W-1:0] lim_y_lo = '0;
    logic signed [COORD_W-1:0] lim_z_lo = '0;
    logic signed [COORD_W-1:0] lim_x_hi = RST_BOUND_X_HIGH;
    logic signed [COORD_W-1:0] lim_y_hi = RST_BOUND_Y_HIGH;
    logic signed [COORD_W-1:0] lim_z_hi = RST_BOUND_Z_HIGH;
    logic [RADIUS_W-1:0]       clearance = '0;

    int send_idle_pct = 11;
    int recv_idle_pct = 60;
    int fault_count = 0;
    int beat_index = 0;
    int quiet_cycles = 0;

    grid_obstacle_collision_checker #(
        .MAX_OBSTACLES(TABLE_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic logic off_axis(logic signed [COORD_W-1:0] p, lo, hi);
        return (p < lo) || (p > hi);
    endfunction

    function automatic t_verdict judge_map_op(t_map_op op);
        t_verdict v;
        longint   dx;
        longint   dy;
        longint   reach;
        v = '0;
        if (op.cmd == CMD_INSERT) begin
            if (obst_count >= TABLE_DEPTH) begin
                v.full = 1'b1;
            end else begin
                obst_x[obst_count] = op.x;
                obst_y[obst_count] = op.y;
                obst_size[obst_count] = op.radius;
                obst_count++;
            end
        end else begin
            v.oob = off_axis(op.x, lim_x_lo, lim_x_hi) || off_axis(op.y, lim_y_lo, lim_y_hi) ||
                    off_axis(op.z, lim_z_lo, lim_z_hi);
            for (int i = 0; i < obst_count; i++) begin
                dx = 16 * (longint'(op.x) - longint'(obst_x[i]));
                dy = 16 * (longint'(op.y) - longint'(obst_y[i]));
                reach = obst_size[i];
                reach = reach + clearance;
                if (dx * dx + dy * dy <= reach * reach) begin
                    v.hit = 1'b1;
                end
            end
        end
        v.count = COUNT_W'(obst_count);
        return v;
    endfunction

    // Sender side: holds a beat until it is taken, predicts its result on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                verdicts = {verdicts, judge_map_op(map_op_on_bus)};
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (map_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    map_op_on_bus = map_ops.pop_front();
                    i_s_axis_tdata <= {4'b0, map_op_on_bus.radius, map_op_on_bus.z,
                                       map_op_on_bus.y, map_op_on_bus.x};
                    i_s_axis_tuser <= map_op_on_bus.cmd;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (cfg_on_bus.index)
                    CFG_BOUND_X_LOW:  lim_x_lo = cfg_on_bus.data;
                    CFG_BOUND_Y_LOW:  lim_y_lo = cfg_on_bus.data;
                    CFG_BOUND_Z_LOW:  lim_z_lo = cfg_on_bus.data;
                    CFG_BOUND_X_HIGH: lim_x_hi = cfg_on_bus.data;
                    CFG_BOUND_Y_HIGH: lim_y_hi = cfg_on_bus.data;
                    CFG_BOUND_Z_HIGH: lim_z_hi = cfg_on_bus.data;
                    CFG_ROBOT_RADIUS: clearance = cfg_on_bus.data[RADIUS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (cfg_writes.size() > 0) begin
                    cfg_on_bus = cfg_writes.pop_front();
                    i_cfg_index <= cfg_on_bus.index;
                    i_cfg_data <= cfg_on_bus.data;
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict seen;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.oob = o_m_axis_tdata[0];
                seen.hit = o_m_axis_tdata[1];
                seen.count = o_m_axis_tdata[8:2];
                seen.full = o_m_axis_tdata[9];
                if (verdicts.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("result beat %0d arrived with no prediction waiting: %h",
                                 beat_index, o_m_axis_tdata);
                    end
                end else begin
                    want = verdicts.pop_front();
                    if (seen != want) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT) begin
                            $display("result beat %0d: expected oob=%0b hit=%0b count=%0d full=%0b,",
                                     beat_index, want.oob, want.hit, want.count, want.full);
                            $display("    got oob=%0b hit=%0b count=%0d full=%0b",
                                     seen.oob, seen.hit, seen.count, seen.full);
                        end
                    end
                end
                beat_index++;
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic t_map_op mk_op(logic cmd, int x, int y, int z, int r);
        t_map_op op;
        op.cmd = cmd;
        op.x = COORD_W'(x);
        op.y = COORD_W'(y);
        op.z = COORD_W'(z);
        op.radius = RADIUS_W'(r);
        return op;
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord();
        return COORD_W'(int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
    endfunction

    function automatic t_map_op random_map_op(int insert_pct);
        t_map_op op;
        int      pick;
        int      anchor;
        op.cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_QUERY;
        op.radius = RADIUS_W'($urandom_range(4095));
        op.z = ($urandom_range(1) == 0) ? near_coord() : COORD_W'($urandom_range(65535));
        pick = $urandom_range(99);
        if (op.cmd == CMD_INSERT) begin
            if (pick < 50) begin
                op.radius = RADIUS_W'($urandom_range(255));
            end else if (pick < 85) begin
                op.radius = RADIUS_W'($urandom_range(1023));
            end
            if ($urandom_range(99) < 70) begin
                op.x = near_coord();
                op.y = near_coord();
            end else begin
                op.x = COORD_W'($urandom_range(65535));
                op.y = COORD_W'($urandom_range(65535));
            end
        end else if (pick < 45 && placed_x.size() > 0) begin
            anchor = $urandom_range(placed_x.size() - 1);
            op.x = COORD_W'(placed_x[anchor] +
                            (int'($urandom_range(2 * OFFSET_SPAN)) - OFFSET_SPAN));
            op.y = COORD_W'(placed_y[anchor] +
                            (int'($urandom_range(2 * OFFSET_SPAN)) - OFFSET_SPAN));
        end else if (pick < 75) begin
            op.x = near_coord();
            op.y = near_coord();
        end else begin
            op.x = COORD_W'($urandom_range(65535));
            op.y = COORD_W'($urandom_range(65535));
        end
        return op;
    endfunction

    task automatic queue_op(t_map_op op);
        if (op.cmd == CMD_INSERT && placed_x.size() < TABLE_DEPTH) begin
            placed_x = {placed_x, op.x};
            placed_y = {placed_y, op.y};
        end
        map_ops = {map_ops, op};
    endtask

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        t_cfg_write w;
        w.index = index;
        w.data = data;
        cfg_writes = {cfg_writes, w};
    endtask

    task automatic drain_traffic();
        do begin
            @(negedge i_clk);
        end while (map_ops.size() != 0 || i_s_axis_tvalid || cfg_writes.size() != 0 ||
                   i_cfg_valid || verdicts.size() != 0);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic set_map_limits(int xl, int yl, int zl, int xh, int yh, int zh, int rr);
        queue_cfg(CFG_BOUND_X_LOW, CFG_DATA_W'(xl));
        queue_cfg(CFG_BOUND_Y_LOW, CFG_DATA_W'(yl));
        queue_cfg(CFG_BOUND_Z_LOW, CFG_DATA_W'(zl));
        queue_cfg(CFG_BOUND_X_HIGH, CFG_DATA_W'(xh));
        queue_cfg(CFG_BOUND_Y_HIGH, CFG_DATA_W'(yh));
        queue_cfg(CFG_BOUND_Z_HIGH, CFG_DATA_W'(zh));
        queue_cfg(CFG_ROBOT_RADIUS, CFG_DATA_W'(rr));
        drain_traffic();
    endtask

    task automatic run_random(int n_ops, int insert_pct);
        for (int i = 0; i < n_ops; i++) begin
            queue_op(random_map_op(insert_pct));
        end
        drain_traffic();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default box is 0..25 on x and y, 0..10 on z, with no robot clearance.
        queue_op(mk_op(CMD_QUERY, 0, 0, 0, 4095));
        queue_op(mk_op(CMD_QUERY, 25, 25, 10, 0));
        queue_op(mk_op(CMD_QUERY, -1, 0, 0, 0));
        queue_op(mk_op(CMD_QUERY, 26, 0, 0, 0));
        queue_op(mk_op(CMD_QUERY, 0, -1, 0, 0));
        queue_op(mk_op(CMD_QUERY, 0, 26, 0, 0));
        queue_op(mk_op(CMD_QUERY, 0, 0, -1, 0));
        queue_op(mk_op(CMD_QUERY, 0, 0, 11, 0));
        queue_op(mk_op(CMD_INSERT, 5, 5, -32768, 48));
        queue_op(mk_op(CMD_QUERY, 5, 5, 5, 0));
        queue_op(mk_op(CMD_QUERY, 8, 5, 0, 0));
        queue_op(mk_op(CMD_QUERY, 9, 5, 0, 0));
        queue_op(mk_op(CMD_QUERY, 5, 2, 0, 0));
        queue_op(mk_op(CMD_INSERT, 20, 10, 32767, 80));
        queue_op(mk_op(CMD_QUERY, 23, 14, 5, 0));
        queue_op(mk_op(CMD_QUERY, 24, 14, 5, 0));
        queue_op(mk_op(CMD_INSERT, -32768, -32768, 0, 0));
        queue_op(mk_op(CMD_QUERY, -32768, -32768, -32768, 0));
        queue_op(mk_op(CMD_QUERY, -32767, -32768, 0, 0));
        queue_op(mk_op(CMD_INSERT, 32767, 32767, 0, 4095));
        queue_op(mk_op(CMD_QUERY, 32512, 32767, 0, 0));
        queue_op(mk_op(CMD_QUERY, 32511, 32767, 0, 0));
        queue_op(mk_op(CMD_QUERY, -32768, 32767, 0, 0));
        queue_op(mk_op(CMD_QUERY, 32767, -32768, -32768, 0));
        drain_traffic();

        set_map_limits(-100, -100, -50, 100, 100, 50, 24);
        run_random(340, 12);

        send_idle_pct = 60;
        recv_idle_pct = 11;
        set_map_limits(-32768, -32768, -32768, 32767, 32767, 32767, 4095);
        run_random(300, 8);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_map_limits(32767, -5, 0, -32768, 5, 0, 0);
        run_random(200, 6);

        queue_cfg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(65535)));
        for (int k = 0; k < 2; k++) begin
            set_map_limits($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(4095));
            run_random(143, 8);
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
